// File: src/u8saf_pkg.sv
// Shared types, character codes and helper functions for the UTF-8 to ASCII folder.
// Used by the front, back, output queue and top-level modules; no dependencies.

package u8saf_pkg;

  // Byte class as seen at a lead position
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_STRAY
  } cls_e;

  // What a decoded code point produces
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CHAR,
    EMIT_DOTS
  } emit_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    cls_e       cls;
  } item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       valid;
    logic       run_last;
    logic       done;
  } result_t;

  typedef struct packed {
    emit_e      kind;
    logic [6:0] ch;
  } fold_t;

  localparam int unsigned FRONT_DEPTH = 2;
  localparam int unsigned OUTQ_DEPTH  = 4;

  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_QMARK = 7'h3F;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_SPACE = 7'h20;

  localparam logic [20:0] CP_ELLIPSIS   = 21'h02026;
  localparam logic [20:0] CP_IDEO_SPACE = 21'h03000;

  function automatic cls_e classify(logic [7:0] b);
    cls_e c;
    if (!b[7]) begin
      c = CLS_ASCII;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c = CLS_LEAD2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c = CLS_LEAD3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_STRAY;
    end
    return c;
  endfunction

  function automatic fold_t fold_cp(logic [20:0] cp);
    fold_t f;
    f.kind = EMIT_NONE;
    f.ch   = CH_NUL;
    if ((cp >= 21'h20 && cp <= 21'h7E) || cp == 21'h0A || cp == 21'h0D || cp == 21'h09) begin
      f.kind = EMIT_CHAR;
      f.ch   = cp[6:0];
    end else begin
      case (cp) inside
        21'h02018, 21'h02019, 21'h02032, 21'h0FF07: begin
          f.kind = EMIT_CHAR;
          f.ch   = CH_APOS;
        end
        21'h0201C, 21'h0201D, 21'h02033, 21'h0FF02: begin
          f.kind = EMIT_CHAR;
          f.ch   = CH_QUOTE;
        end
        [21'h02010:21'h02014], 21'h02212, 21'h0FF0D: begin
          f.kind = EMIT_CHAR;
          f.ch   = CH_DASH;
        end
        CP_ELLIPSIS: begin
          f.kind = EMIT_DOTS;
          f.ch   = CH_DOT;
        end
        21'h000A0, [21'h02000:21'h0200A], 21'h0202F, 21'h0205F, CP_IDEO_SPACE: begin
          f.kind = EMIT_CHAR;
          f.ch   = CH_SPACE;
        end
        default: begin
          f.kind = EMIT_NONE;
        end
      endcase
    end
    return f;
  endfunction

endpackage

// File: src/u8saf_front.sv
// Input side: a two-entry shifting queue that classifies each byte as it enters.
// Depends on u8saf_pkg (item_t, classify).

module u8saf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          data_i,
  input  logic                eos_i,
  output logic                full_o,
  output logic                item_valid_o,
  output u8saf_pkg::item_t    item_o,
  input  logic                item_pop_i
);

  localparam int unsigned Depth = u8saf_pkg::FRONT_DEPTH;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  u8saf_pkg::item_t q_q [Depth];
  u8saf_pkg::item_t q_d [Depth];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  wr_cnt;
  logic             do_push, do_pop;
  u8saf_pkg::item_t new_item;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_q[0];

  assign do_push = push_i && !full_o;
  assign do_pop  = item_pop_i && item_valid_o;
  assign wr_cnt  = cnt_q - CntW'(do_pop);

  always_comb begin
    new_item.data = data_i;
    new_item.eos  = eos_i;
    new_item.cls  = u8saf_pkg::classify(data_i);
  end

  always_comb begin
    q_d = q_q;
    if (do_pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    if (do_push) begin
      q_d[wr_cnt[IdxW-1:0]] = new_item;
    end
  end

  always_comb begin
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

// File: src/u8saf_back.sv
// Sequencer: assembles UTF-8 sequences, replays bad continuations, folds code points,
// and tags the last result of each byte. Depends on u8saf_pkg.

module u8saf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  u8saf_pkg::item_t     item_i,
  output logic                 item_pop_o,
  output logic                 res_push_o,
  output u8saf_pkg::result_t   res_o,
  input  logic                 res_full_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_REP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      pb_q [4];
  logic [1:0]      pc_q, pc_d;
  logic [2:0]      el_q, el_d;
  logic [7:0]      wq_q [3];
  logic [7:0]      wq_d [3];
  logic [1:0]      wn_q, wn_d;
  logic [1:0]      rep_q, rep_d;
  logic            eos_q, eos_d;
  logic            hold_v_q, hold_v_d;
  logic [6:0]      hold_ch_q, hold_ch_d;

  // step datapath
  logic [7:0]        cur_b;
  u8saf_pkg::cls_e   cur_cls;
  logic [1:0]        rem_n;
  logic [7:0]        seq [4];
  logic [7:0]        rest [2];
  logic              seq_done, cont_ok;
  logic [1:0]        nr;
  logic [20:0]       dec_cp, cp_sel;
  u8saf_pkg::fold_t  fold;
  u8saf_pkg::emit_e  st_emit;
  logic [6:0]        st_ch;
  logic [1:0]        st_pc;
  logic [2:0]        st_el;
  logic              pb_we;
  logic [1:0]        pb_idx;
  logic [7:0]        st_wq [3];
  logic [1:0]        st_wn;

  // cycle control
  logic              active, produce, final_push, trunc, stall, fire;
  logic [6:0]        prod_ch;

  assign cur_b   = (state_q == ST_IDLE) ? item_i.data : wq_q[0];
  assign cur_cls = (state_q == ST_IDLE) ? item_i.cls : u8saf_pkg::classify(wq_q[0]);
  assign rem_n   = (state_q == ST_IDLE) ? 2'd0 : wn_q - 2'd1;
  assign rest[0] = wq_q[1];
  assign rest[1] = wq_q[2];

  always_comb begin
    seq[0] = pb_q[0];
    for (int i = 1; i < 4; i++) begin
      seq[i] = (pc_q == 2'(i)) ? cur_b : pb_q[i];
    end
  end

  assign seq_done = ({1'b0, pc_q} + 3'd1) >= el_q;
  assign cont_ok  = (seq[1][7:6] == 2'b10)
                 && ((el_q < 3'd3) || (seq[2][7:6] == 2'b10))
                 && ((el_q < 3'd4) || (seq[3][7:6] == 2'b10));
  assign nr       = 2'(el_q - 3'd1);

  always_comb begin
    case (el_q)
      3'd2:    dec_cp = {10'd0, seq[0][4:0], seq[1][5:0]};
      3'd3:    dec_cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      default: dec_cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
    endcase
  end

  assign cp_sel = (pc_q == 2'd0) ? {13'd0, cur_b} : dec_cp;
  assign fold   = u8saf_pkg::fold_cp(cp_sel);

  always_comb begin
    st_emit  = u8saf_pkg::EMIT_NONE;
    st_ch    = u8saf_pkg::CH_QMARK;
    st_pc    = pc_q;
    st_el    = el_q;
    pb_we    = 1'b0;
    pb_idx   = pc_q;
    st_wq[0] = wq_q[1];
    st_wq[1] = wq_q[2];
    st_wq[2] = wq_q[2];
    st_wn    = rem_n;
    if (pc_q == 2'd0) begin
      st_el = 3'd0;
      case (cur_cls)
        u8saf_pkg::CLS_ASCII: begin
          st_emit = fold.kind;
          st_ch   = fold.ch;
        end
        u8saf_pkg::CLS_LEAD2: begin
          pb_we = 1'b1;
          st_pc = 2'd1;
          st_el = 3'd2;
        end
        u8saf_pkg::CLS_LEAD3: begin
          pb_we = 1'b1;
          st_pc = 2'd1;
          st_el = 3'd3;
        end
        u8saf_pkg::CLS_LEAD4: begin
          pb_we = 1'b1;
          st_pc = 2'd1;
          st_el = 3'd4;
        end
        default: begin
          st_emit = u8saf_pkg::EMIT_CHAR;
        end
      endcase
    end else begin
      pb_we = 1'b1;
      if (!seq_done) begin
        st_pc = pc_q + 2'd1;
      end else begin
        st_pc = 2'd0;
        st_el = 3'd0;
        if (cont_ok) begin
          st_emit = fold.kind;
          st_ch   = fold.ch;
        end else begin
          // replay the bytes after the lead ahead of whatever is still queued
          st_emit  = u8saf_pkg::EMIT_CHAR;
          st_wq[0] = seq[1];
          st_wq[1] = (nr >= 2'd2) ? seq[2] : rest[0];
          st_wq[2] = (nr == 2'd3) ? seq[3] : ((nr == 2'd2) ? rest[0] : rest[1]);
          st_wn    = nr + rem_n;
        end
      end
    end
  end

  always_comb begin
    active     = 1'b0;
    produce    = 1'b0;
    final_push = 1'b0;
    trunc      = 1'b0;
    prod_ch    = st_ch;
    case (state_q)
      ST_IDLE: begin
        active  = item_valid_i;
        produce = (st_emit != u8saf_pkg::EMIT_NONE);
      end
      ST_RUN: begin
        active  = 1'b1;
        produce = (st_emit != u8saf_pkg::EMIT_NONE);
      end
      ST_REP: begin
        active  = 1'b1;
        produce = 1'b1;
        prod_ch = u8saf_pkg::CH_DOT;
      end
      ST_FIN: begin
        active = 1'b1;
        if (eos_q && pc_q != 2'd0) begin
          trunc   = 1'b1;
          produce = 1'b1;
          prod_ch = u8saf_pkg::CH_QMARK;
        end else begin
          final_push = hold_v_q || eos_q;
        end
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  assign stall = res_full_i && ((produce && hold_v_q) || final_push);
  assign fire  = active && !stall;

  assign item_pop_o = fire && (state_q == ST_IDLE);
  assign res_push_o = fire && ((produce && hold_v_q) || final_push);

  always_comb begin
    if (final_push) begin
      res_o.ch       = hold_v_q ? hold_ch_q : u8saf_pkg::CH_NUL;
      res_o.valid    = hold_v_q;
      res_o.run_last = 1'b1;
      res_o.done     = eos_q;
    end else begin
      res_o.ch       = hold_ch_q;
      res_o.valid    = 1'b1;
      res_o.run_last = 1'b0;
      res_o.done     = 1'b0;
    end
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    el_d      = el_q;
    wq_d      = wq_q;
    wn_d      = wn_q;
    rep_d     = rep_q;
    eos_d     = eos_q;
    hold_v_d  = hold_v_q;
    hold_ch_d = hold_ch_q;
    if (fire) begin
      if (produce) begin
        hold_v_d  = 1'b1;
        hold_ch_d = prod_ch;
      end
      case (state_q)
        ST_IDLE, ST_RUN: begin
          if (state_q == ST_IDLE) begin
            eos_d = item_i.eos;
          end
          pc_d = st_pc;
          el_d = st_el;
          wq_d = st_wq;
          wn_d = st_wn;
          if (st_emit == u8saf_pkg::EMIT_DOTS) begin
            rep_d   = 2'd2;
            state_d = ST_REP;
          end else if (st_wn != 2'd0) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
        ST_REP: begin
          rep_d = rep_q - 2'd1;
          if (rep_q == 2'd1) begin
            state_d = (wn_q != 2'd0) ? ST_RUN : ST_FIN;
          end
        end
        ST_FIN: begin
          if (trunc) begin
            pc_d = 2'd0;
            el_d = 3'd0;
          end else begin
            hold_v_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pc_q     <= '0;
      el_q     <= '0;
      wn_q     <= '0;
      rep_q    <= '0;
      eos_q    <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      el_q     <= el_d;
      wn_q     <= wn_d;
      rep_q    <= rep_d;
      eos_q    <= eos_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_ch_q <= hold_ch_d;
    wq_q      <= wq_d;
    if (fire && pb_we && (state_q == ST_IDLE || state_q == ST_RUN)) begin
      pb_q[pb_idx] <= cur_b;
    end
  end

endmodule

// File: src/u8saf_outq.sv
// Result queue: a four-entry shifting queue between the sequencer and the output port.
// Depends on u8saf_pkg (result_t, OUTQ_DEPTH).

module u8saf_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u8saf_pkg::result_t  res_i,
  output logic                full_o,
  output logic                empty_o,
  output u8saf_pkg::result_t  res_o,
  input  logic                pop_i
);

  localparam int unsigned Depth = u8saf_pkg::OUTQ_DEPTH;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  u8saf_pkg::result_t q_q [Depth];
  u8saf_pkg::result_t q_d [Depth];
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    wr_cnt;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = q_q[0];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign wr_cnt  = cnt_q - CntW'(do_pop);

  always_comb begin
    q_d = q_q;
    if (do_pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    if (do_push) begin
      q_d[wr_cnt[IdxW-1:0]] = res_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

// File: src/utf8_to_safe_ascii_folder_top.sv
// Top level of the UTF-8 to safe ASCII folder: input queue, sequencer, result queue.
// Depends on u8saf_pkg, u8saf_front, u8saf_back and u8saf_outq.
//
// Usage:
//   Input channel: drive in_byte_i and end_of_string_i with push high; the beat is
//   taken on a rising edge where full is low. Mark the last byte of each string.
//   Result channel: while empty is low the oldest result sits on out_char_o,
//   char_valid_o, run_last_o and string_done_o; raise pop to take the beat.
//   run_last_o flags the last result caused by a byte; a byte that ends a string
//   and yields no character gives one bare end marker (char_valid_o low).
// Sequencing:
//   In the sequencer a byte that yields at most one character is taken and classified,
//   then closed out; the sequencer takes the next byte only once it has closed out
//   the last one. Each byte replayed after a bad continuation adds a step, an ellipsis
//   adds a step for each extra dot, and a truncated string adds one for its '?'.
//   A byte's first result is held in the sequencer, then registered in the result queue.
// Reset and stalls:
//   Reset empties both queues and drops any half-built sequence. When the
//   receiver stops popping, the four-entry result queue fills, the sequencer
//   holds, and full rises once the two-entry input queue is occupied.

module utf8_to_safe_ascii_folder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       char_valid_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  logic               item_valid, item_pop;
  u8saf_pkg::item_t   item;
  logic               res_push, res_full;
  u8saf_pkg::result_t res_in, res_out;

  u8saf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_i       (in_byte_i),
    .eos_i        (end_of_string_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  u8saf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  u8saf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .res_o   (res_out),
    .pop_i   (pop)
  );

  assign out_char_o    = res_out.ch;
  assign char_valid_o  = res_out.valid;
  assign run_last_o    = res_out.run_last;
  assign string_done_o = res_out.done;

`ifndef SYNTHESIS
  // a bare end marker only closes a string and carries no character
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !char_valid_o) |-> (run_last_o && string_done_o && out_char_o == 7'h00))
    else $error("bare end marker without end flags or with a character");

  // the end of a string is always the last result of its byte
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && string_done_o) |-> run_last_o)
    else $error("string_done without run_last");

  // only printable ASCII, tab, LF or CR ever leaves the block
  a_safe_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_valid_o) |->
      ((out_char_o >= 7'h20 && out_char_o <= 7'h7E) || out_char_o == 7'h09 ||
       out_char_o == 7'h0A || out_char_o == 7'h0D))
    else $error("unsafe character on output");
`endif

endmodule
